[design/address_rw_lock_table_core_assert.svh]
// Assertion macros for the lock table checker
`ifndef ADDRESS_RW_LOCK_TABLE_CORE_ASSERT_SVH
`define ADDRESS_RW_LOCK_TABLE_CORE_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define ARW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Check an implication in the cycle after the antecedent
`define ARW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/arwlt_pkg.sv]
// ----------------------------------------------------------------------------
// arwlt_pkg
// Types and constants shared by the address lock table modules.
// ----------------------------------------------------------------------------
package arwlt_pkg;

    localparam int BUCKETS    = 64;
    localparam int WAYS       = 4;
    localparam int NODES      = 48;
    localparam int ADDR_W     = 32;
    localparam int ENTRIES    = BUCKETS * WAYS;
    localparam int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int WAYCNT_W   = $clog2(WAYS + 1);
    localparam int ENTCNT_W   = $clog2(ENTRIES + 1);
    localparam int NODE_W     = 6;
    localparam int CMD_W      = 3;

    localparam logic [CMD_W-1:0] CMD_ACQ_READ  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ACQ_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REL_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REL_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REL_NODE  = 3'd4;

    localparam logic [1:0] CONF_NONE = 2'd0;
    localparam logic [1:0] CONF_WAW  = 2'd1;
    localparam logic [1:0] CONF_WAR  = 2'd2;
    localparam logic [1:0] CONF_RAW  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic way_read;   // read entry at search pointer
        logic way_next;   // evaluate read entry, advance pointer
        logic update;     // apply acquire/release on found entry
        logic sweep_read; // read entry at sweep pointer
        logic sweep_next; // write back swept entry, advance
        logic out_load;   // present result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic search_last; // last way evaluated
        logic sweep_last;  // last entry written back
        logic is_node_rel; // request is release node
        logic is_table;    // request touches one bucket
        logic out_busy;    // result register holds unread result
    } t_status;

endpackage

[design/arwlt_ctrl.sv]
// ----------------------------------------------------------------------------
// arwlt_ctrl
// Sequencer: bucket search, entry update and node release sweep.
// ----------------------------------------------------------------------------
module arwlt_ctrl
    import arwlt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_rd;  // a read is in flight from memory
    logic   n_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rd    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rd    <= n_rd;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rd    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    priority if (i_status.is_node_rel) n_state = ST_SWEEP;
                    else if (i_status.is_table) n_state = ST_SEARCH;
                    else n_state = ST_DONE;
                end
            end
            ST_SEARCH: begin
                n_rd = !r_rd || !i_status.search_last;
                if (r_rd && i_status.search_last) n_state = ST_UPDATE;
            end
            ST_UPDATE: n_state = ST_DONE;
            ST_SWEEP: begin
                n_rd = !r_rd || !i_status.sweep_last;
                if (r_rd && i_status.sweep_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_SEARCH: begin
                o_cmd.way_read = !r_rd || !i_status.search_last;
                o_cmd.way_next = r_rd;
            end
            ST_UPDATE: o_cmd.update = 1'b1;
            ST_SWEEP: begin
                o_cmd.sweep_read = !r_rd || !i_status.sweep_last;
                o_cmd.sweep_next = r_rd;
            end
            ST_DONE: o_cmd.out_load = !i_status.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

[design/arwlt_datapath.sv]
// ----------------------------------------------------------------------------
// arwlt_datapath
// Entry memory, valid bits, request registers and result register.
// ----------------------------------------------------------------------------
module arwlt_datapath
    import arwlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node_id,
    input  logic [ADDR_W-1:0] i_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_conflict,
    output logic              o_table_full
);

    localparam int ENTRY_BITS = ADDR_W + NODES + 1 + NODE_W;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [NODES-1:0]  readers;
        logic              wr_p;
        logic [NODE_W-1:0] wr_n;
    } t_entry;

    // Entry storage: one write port, one registered read port
    logic [ENTRY_BITS-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0]    r_ent_valid;

    logic [CMD_W-1:0]  r_cmd;
    logic [NODE_W-1:0] r_node;
    logic [ADDR_W-1:0] r_addr;
    logic [WAY_W-1:0]  r_way;      // way being read
    logic [WAY_W-1:0]  r_eval_way; // way of data in r_rd_data
    logic [ENT_W-1:0]  r_sw;       // sweep read pointer
    logic [ENT_W-1:0]  r_sw_eval;
    t_entry            r_rd_data;
    logic              r_found, r_free_ok;
    logic [WAY_W-1:0]  r_hit_way, r_free_way;
    t_entry            r_hit_data;
    logic [1:0]        r_conf;
    logic              r_full;
    logic              r_out_valid;
    logic [1:0]        r_out_conf;
    logic              r_out_full;

    logic [BKT_W-1:0]  bucket;
    logic [ENT_W-1:0]  base_idx;
    logic [NODES-1:0]  node_bit;
    logic [ENT_W-1:0]  rd_idx;
    logic              rd_en;
    logic              eval_valid;
    logic              wr_en;
    logic [ENT_W-1:0]  wr_idx;
    t_entry            wr_data;
    logic              clr_valid, set_valid;
    logic [1:0]        upd_conf;
    logic              upd_full;
    t_entry            upd_ent;
    logic              upd_keep;
    t_entry            sw_ent;

    assign bucket   = r_addr[BKT_W-1:0] & BKT_W'(BUCKETS - 1);
    assign base_idx = ENT_W'(bucket) * ENT_W'(WAYS);
    assign node_bit = NODES'(1) << r_node;

    assign rd_en  = i_cmd.way_read || i_cmd.sweep_read;
    assign rd_idx = i_cmd.sweep_read ? r_sw : ENT_W'(base_idx + ENT_W'(r_way));

    assign eval_valid = r_ent_valid[ENT_W'(base_idx + ENT_W'(r_eval_way))];

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= t_entry'(r_mem[rd_idx]);
        if (wr_en) r_mem[wr_idx] <= ENTRY_BITS'(wr_data);
    end

    // Acquire/release on the located entry
    always_comb begin
        upd_conf = CONF_NONE;
        upd_full = 1'b0;
        upd_ent  = r_hit_data;
        upd_keep = 1'b1;
        wr_en    = 1'b0;
        wr_idx   = ENT_W'(base_idx + ENT_W'(r_hit_way));
        wr_data  = r_hit_data;
        set_valid = 1'b0;
        clr_valid = 1'b0;
        if (r_cmd == CMD_ACQ_READ || r_cmd == CMD_ACQ_WRITE) begin
            if (!r_found) begin
                upd_ent.addr    = r_addr;
                upd_ent.readers = '0;
                upd_ent.wr_p    = 1'b0;
                upd_ent.wr_n    = '0;
                wr_idx          = ENT_W'(base_idx + ENT_W'(r_free_way));
            end
            if (!r_found && !r_free_ok) begin
                upd_full = 1'b1;
            end else begin
                if (r_cmd == CMD_ACQ_WRITE) begin
                    priority if (upd_ent.wr_p) upd_conf = CONF_WAW;
                    else if (upd_ent.readers != '0 && upd_ent.readers != node_bit)
                        upd_conf = CONF_WAR;
                    else begin
                        upd_ent.wr_p = 1'b1;
                        upd_ent.wr_n = r_node;
                    end
                end else begin
                    if (upd_ent.wr_p && upd_ent.wr_n != r_node) upd_conf = CONF_RAW;
                    else upd_ent.readers = upd_ent.readers | node_bit;
                end
                // A new entry never conflicts, so it is always kept
                wr_en     = i_cmd.update;
                set_valid = i_cmd.update && !r_found;
            end
        end else if (r_found) begin
            if (r_cmd == CMD_REL_READ) upd_ent.readers = upd_ent.readers & ~node_bit;
            else if (upd_ent.wr_p && upd_ent.wr_n == r_node) upd_ent.wr_p = 1'b0;
            upd_keep  = (upd_ent.readers != '0) || upd_ent.wr_p;
            wr_en     = i_cmd.update;
            clr_valid = i_cmd.update && !upd_keep;
        end
        wr_data = upd_ent;

        sw_ent = r_rd_data;
        if (sw_ent.wr_p && sw_ent.wr_n == r_node) sw_ent.wr_p = 1'b0;
        sw_ent.readers = sw_ent.readers & ~node_bit;
        if (i_cmd.sweep_next) begin
            wr_en   = r_ent_valid[r_sw_eval];
            wr_idx  = r_sw_eval;
            wr_data = sw_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (set_valid) r_ent_valid[wr_idx] <= 1'b1;
            if (clr_valid) r_ent_valid[wr_idx] <= 1'b0;
            if (i_cmd.sweep_next && r_ent_valid[r_sw_eval]
                    && sw_ent.readers == '0 && !sw_ent.wr_p)
                r_ent_valid[r_sw_eval] <= 1'b0;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_command;
            r_node     <= i_node_id;
            r_addr     <= i_address;
            r_way      <= '0;
            r_eval_way <= '0;
            r_sw       <= '0;
            r_sw_eval  <= '0;
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
            r_hit_way  <= '0;
            r_free_way <= '0;
            r_conf     <= CONF_NONE;
            r_full     <= 1'b0;
        end
        if (i_cmd.way_read) r_way <= WAY_W'(r_way + WAY_W'(1));
        if (i_cmd.way_next) begin
            r_eval_way <= WAY_W'(r_eval_way + WAY_W'(1));
            if (eval_valid && !r_found && r_rd_data.addr == r_addr) begin
                r_found    <= 1'b1;
                r_hit_way  <= r_eval_way;
                r_hit_data <= r_rd_data;
            end
            if (!eval_valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_way <= r_eval_way;
            end
        end
        if (i_cmd.sweep_read) r_sw <= ENT_W'(r_sw + ENT_W'(1));
        if (i_cmd.sweep_next) r_sw_eval <= ENT_W'(r_sw_eval + ENT_W'(1));
        if (i_cmd.update) begin
            r_conf <= upd_conf;
            r_full <= upd_full;
        end
        if (i_cmd.out_load) begin
            r_out_conf <= r_conf;
            r_out_full <= r_full;
        end
    end

    assign o_status.search_last = (r_eval_way == WAY_W'(WAYS - 1));
    assign o_status.sweep_last  = (r_sw_eval == ENT_W'(ENTRIES - 1));
    assign o_status.is_node_rel = (i_command == CMD_REL_NODE) && (i_node_id < NODE_W'(NODES));
    assign o_status.is_table    = (i_node_id < NODE_W'(NODES)) &&
        (i_command == CMD_ACQ_READ || i_command == CMD_ACQ_WRITE ||
         i_command == CMD_REL_READ || i_command == CMD_REL_WRITE);
    assign o_status.out_busy    = r_out_valid && i_stall;

    assign o_valid      = r_out_valid;
    assign o_conflict   = r_out_conf;
    assign o_table_full = r_out_full;

endmodule

[design/address_rw_lock_table_core.sv]
// ----------------------------------------------------------------------------
// address_rw_lock_table_core
// Reader/writer lock table keyed by address, set-associative buckets.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one request: command, node, address.
//   Output channel o_valid/i_stall returns conflict code and table_full flag.
//   One request is handled at a time. A bucket command reads the WAYS entries
//   of its bucket from the entry memory one per cycle, then updates one entry;
//   the single memory read port sets this pace. Release node sweeps every
//   entry through that port. Ignored commands skip the search and go straight
//   to the result.
//   The result register holds the result while i_stall is high. The next
//   request is still accepted, but it waits in its last cycle until the
//   result register is free.
//   Reset clears all entry valid bits at once and empties the result register;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
module address_rw_lock_table_core
    import arwlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node_id,
    input  logic [ADDR_W-1:0] i_address,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_conflict,
    output logic              o_table_full
);

    t_cmd    cmd;
    t_status status;

    arwlt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    arwlt_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_command    (i_command),
        .i_node_id    (i_node_id),
        .i_address    (i_address),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_conflict   (o_conflict),
        .o_table_full (o_table_full)
    );

endmodule

[design/arwlt_checker.sv]
// ----------------------------------------------------------------------------
// arwlt_checker
// Port-level checks for the address lock table.
// ----------------------------------------------------------------------------
`include "address_rw_lock_table_core_assert.svh"

module arwlt_checker
    import arwlt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [1:0]        o_conflict,
    input logic              o_table_full
);

    // A request accepted means the block goes busy
    `ARW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // A full table never comes with a conflict
    `ARW_ASSERT_IMP(a_full_no_conflict, i_clk, i_rst_n, o_valid && o_conflict != CONF_NONE,
        !o_table_full)
    // A freshly loaded result leaves the block ready for the next request
    `ARW_ASSERT_NEXT(a_ready_with_result, i_clk, i_rst_n, !o_valid, !o_valid || !o_stall)
    // A stalled result holds
    `ARW_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_conflict) && $stable(o_table_full))

endmodule

bind address_rw_lock_table_core arwlt_checker u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_conflict   (o_conflict),
    .o_table_full (o_table_full)
);

[sim/lock_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lock_table_checker
// Watches the request and result channels of the lock table, keeps its own
// copy of the table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module lock_table_checker
    import arwlt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_o_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [NODE_W-1:0] i_node_id,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_o_valid,
    input  logic              i_stall,
    input  logic [1:0]        i_conflict,
    input  logic              i_table_full,
    output int                o_errors,
    output int                o_pending
);

    typedef struct packed {
        logic [1:0] conflict;
        logic       full;
    } t_lock_result;

    logic              lk_valid  [ENTRIES];
    logic [ADDR_W-1:0] lk_addr   [ENTRIES];
    logic [NODES-1:0]  lk_readers[ENTRIES];
    logic              lk_has_wr [ENTRIES];
    logic [NODE_W-1:0] lk_writer [ENTRIES];

    t_lock_result expected_results[$];

    function automatic int find_lock(int base, logic [ADDR_W-1:0] addr);
        for (int w = 0; w < WAYS; w++) begin
            if (lk_valid[base + w] && lk_addr[base + w] == addr) return base + w;
        end
        return -1;
    endfunction

    function automatic void drop_if_empty(int e);
        if (lk_readers[e] == '0 && !lk_has_wr[e]) lk_valid[e] = 1'b0;
    endfunction

    function automatic t_lock_result predict_lock(logic [CMD_W-1:0] cmd,
                                                  logic [NODE_W-1:0] node,
                                                  logic [ADDR_W-1:0] addr);
        t_lock_result r;
        int base;
        int e;
        logic [NODES-1:0] bit_n;
        r = '0;
        base = int'(addr % BUCKETS) * WAYS;
        if (node >= NODES) return r;
        bit_n = '0;
        bit_n[node] = 1'b1;
        if (cmd == CMD_ACQ_READ || cmd == CMD_ACQ_WRITE) begin
            e = find_lock(base, addr);
            if (e < 0) begin
                for (int w = 0; w < WAYS; w++) begin
                    if (e < 0 && !lk_valid[base + w]) e = base + w;
                end
                if (e < 0) begin
                    r.full = 1'b1;
                end else begin
                    lk_valid[e] = 1'b1;
                    lk_addr[e] = addr;
                    lk_readers[e] = '0;
                    lk_has_wr[e] = 1'b0;
                    lk_writer[e] = '0;
                end
            end
            if (e >= 0) begin
                if (cmd == CMD_ACQ_WRITE) begin
                    if (lk_has_wr[e]) r.conflict = CONF_WAW;
                    else if (lk_readers[e] != '0 && lk_readers[e] != bit_n)
                        r.conflict = CONF_WAR;
                    else begin
                        lk_has_wr[e] = 1'b1;
                        lk_writer[e] = node;
                    end
                end else if (lk_has_wr[e] && lk_writer[e] != node) begin
                    r.conflict = CONF_RAW;
                end else begin
                    lk_readers[e] |= bit_n;
                end
            end
        end else if (cmd == CMD_REL_READ || cmd == CMD_REL_WRITE) begin
            e = find_lock(base, addr);
            if (e >= 0) begin
                if (cmd == CMD_REL_READ) lk_readers[e] &= ~bit_n;
                else if (lk_has_wr[e] && lk_writer[e] == node) lk_has_wr[e] = 1'b0;
                drop_if_empty(e);
            end
        end else if (cmd == CMD_REL_NODE) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (lk_valid[i]) begin
                    if (lk_has_wr[i] && lk_writer[i] == node) lk_has_wr[i] = 1'b0;
                    lk_readers[i] &= ~bit_n;
                    drop_if_empty(i);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_lock_result got;
        t_lock_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                lk_valid[i] = 1'b0;
                lk_addr[i] = '0;
                lk_readers[i] = '0;
                lk_has_wr[i] = 1'b0;
                lk_writer[i] = '0;
            end
            expected_results.delete();
            o_errors = 0;
        end else begin
            if (i_o_valid && !i_stall) begin
                got.conflict = i_conflict;
                got.full = i_table_full;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result conflict=%0d full=%0d",
                             $time, got.conflict, got.full);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.conflict !== want.conflict) begin
                        $display("%0t: conflict mismatch expected %0d actual %0d",
                                 $time, want.conflict, got.conflict);
                        o_errors++;
                    end
                    if (got.full !== want.full) begin
                        $display("%0t: table_full mismatch expected %0d actual %0d",
                                 $time, want.full, got.full);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !i_o_stall)
                expected_results.push_back(predict_lock(i_command, i_node_id, i_address));
        end
        o_pending = expected_results.size();
    end

endmodule

[sim/tb_address_rw_lock_table_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_address_rw_lock_table_core
// Drives directed and random lock requests with random gaps and result
// stalls, including a long result hold-off; the checker judges each result.
// ----------------------------------------------------------------------------
module tb_address_rw_lock_table_core;
    import arwlt_pkg::*;

    localparam int RANDOM_REQS = 650;
    localparam int WATCHDOG    = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [CMD_W-1:0]  i_command = CMD_ACQ_READ;
    logic [NODE_W-1:0] i_node_id = '0;
    logic [ADDR_W-1:0] i_address = '0;
    logic              o_valid;
    logic              i_stall = 1'b1;
    logic [1:0]        o_conflict;
    logic              o_table_full;

    int  errors;
    int  pending;
    bit  hold_off = 1'b0;
    bit  stim_done = 1'b0;
    int  idle_cycles = 0;
    int  out_wait = 0;

    logic [ADDR_W-1:0] hot_addr[8];

    always #6 i_clk = ~i_clk;

    address_rw_lock_table_core dut (.*);

    lock_table_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_o_stall(o_stall),
        .i_command(i_command), .i_node_id(i_node_id), .i_address(i_address),
        .i_o_valid(o_valid), .i_stall(i_stall), .i_conflict(o_conflict),
        .i_table_full(o_table_full), .o_errors(errors), .o_pending(pending)
    );

    // Leave valid high after acceptance; the next request or an idle drop follows
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [NODE_W-1:0] node,
                                logic [ADDR_W-1:0] addr);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_node_id <= node;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid and wait until every expected result has come
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
    endtask

    // Mostly real nodes and commands on a small set of hot addresses
    task automatic send_random_request();
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node;
        logic [ADDR_W-1:0] addr;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) cmd = CMD_REL_NODE;
        else if (pick < 6) cmd = CMD_W'($urandom_range(5, 7));
        else cmd = CMD_W'($urandom_range(0, 3));
        node = $urandom_range(0, 19) == 0 ? NODE_W'($urandom_range(0, 63))
                                          : NODE_W'($urandom_range(0, 5));
        if ($urandom_range(0, 9) < 8) addr = hot_addr[$urandom_range(0, 7)];
        else addr = $urandom();
        send_request(cmd, node, addr);
    endtask

    // Result side: a random wait per result, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall) begin
            out_wait = $urandom_range(0, 15);
            i_stall <= (out_wait != 0);
        end else if (out_wait > 0) begin
            out_wait--;
            i_stall <= (out_wait != 0);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("address_rw_lock_table_core test failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++)
            hot_addr[i] = {$urandom_range(0, 3) == 0 ? 26'h3ffffff : 26'($urandom()),
                           6'($urandom_range(0, 1) ? 5 : $urandom_range(0, 63))};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, each command and the special cases
        send_request(CMD_ACQ_READ, 6'd0, 32'h0000_0000);
        send_request(CMD_ACQ_READ, 6'd47, 32'hFFFF_FFFF);
        send_request(CMD_ACQ_READ, 6'd47, 32'hFFFF_FFFF);   // repeated read
        send_request(CMD_ACQ_WRITE, 6'd47, 32'hFFFF_FFFF);  // sole reader upgrades
        send_request(CMD_ACQ_WRITE, 6'd47, 32'hFFFF_FFFF);  // writer asks again
        send_request(CMD_ACQ_READ, 6'd3, 32'hFFFF_FFFF);    // read after write
        send_request(CMD_ACQ_READ, 6'd5, 32'h0000_0000);
        send_request(CMD_ACQ_WRITE, 6'd5, 32'h0000_0000);   // write after read
        send_request(CMD_REL_WRITE, 6'd9, 32'hFFFF_FFFF);   // not the writer
        send_request(CMD_REL_WRITE, 6'd47, 32'hFFFF_FFFF);
        send_request(CMD_REL_READ, 6'd47, 32'hFFFF_FFFF);
        send_request(CMD_REL_READ, 6'd1, 32'h1234_5678);    // absent address
        // Fill bucket 5, then overflow it
        for (int i = 0; i < 5; i++)
            send_request(CMD_ACQ_WRITE, 6'(i), 32'(i * 64 + 5));
        send_request(CMD_ACQ_WRITE, 6'd2, 32'h0000_0045);   // write after write
        send_request(CMD_ACQ_READ, 6'd1, 32'h0000_0045);    // writer reads its own
        send_request(CMD_ACQ_READ, 6'd48, 32'h0000_0005);   // node out of range
        send_request(CMD_ACQ_READ, 6'd63, 32'h0000_0005);
        send_request(3'd7, 6'd1, 32'h0000_0005);            // unknown command
        send_request(3'd5, 6'd1, 32'h0000_0005);
        send_request(CMD_REL_NODE, 6'd1, 32'hA5A5_A5A5);
        send_request(CMD_REL_NODE, 6'd63, 32'h0);

        // Pause until everything has drained
        drain();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n == 200) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            if (n == 400) drain();
            send_random_request();
        end

        drain();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("address_rw_lock_table_core test passed");
        end else begin
            $display("address_rw_lock_table_core test failed");
        end
        $finish;
    end

endmodule
